>>> sv/b64_pkg.sv
// types, constants and status codes for the base64 stream decoder
// used by the character classifier, the step logic and the top level
package b64_pkg;

  localparam int unsigned QuartetLen = 4;
  localparam int unsigned SextetW    = 7;
  localparam logic [SextetW-1:0] PadMark = 7'd64;

  localparam logic [7:0] CharPad = 8'h3d;

  localparam int unsigned PaddrW = 3;
  localparam logic [0:0] RegSkipJunk = 1'b0;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StInvalid = 2'd1,
    StShort   = 2'd2
  } status_e;

  // classification of one text byte
  typedef struct packed {
    logic       is_space;
    logic       is_alpha;
    logic       is_pad;
    logic [5:0] value;
  } char_info_t;

  // decoder state carried from byte to byte
  typedef struct packed {
    logic [QuartetLen-1:0][SextetW-1:0] sextets;
    logic [1:0]                         fill_count;
    logic                               data_finished;
    logic                               error_seen;
  } dec_state_t;

  // one result item
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] count;
    status_e    status;
  } dec_result_t;

endpackage

>>> sv/b64_char_class.sv
// character classifier: whitespace, alphabet value, pad
// depends on b64_pkg
module b64_char_class (
  input  logic [7:0]          char_i,
  output b64_pkg::char_info_t info_o
);

  always_comb begin
    info_o          = '0;
    info_o.is_pad   = (char_i == b64_pkg::CharPad);
    info_o.is_space = 1'b0;
    case (char_i) inside
      8'h20, 8'h09, 8'h0a, 8'h0d, 8'h0c, 8'h0b: begin
        info_o.is_space = 1'b1;
      end
      [8'h41:8'h5a]: begin
        info_o.is_alpha = 1'b1;
        info_o.value    = 6'(char_i - 8'h41);
      end
      [8'h61:8'h7a]: begin
        info_o.is_alpha = 1'b1;
        info_o.value    = 6'(char_i - 8'h61 + 8'd26);
      end
      [8'h30:8'h39]: begin
        info_o.is_alpha = 1'b1;
        info_o.value    = 6'(char_i - 8'h30 + 8'd52);
      end
      8'h2b: begin
        info_o.is_alpha = 1'b1;
        info_o.value    = 6'd62;
      end
      8'h2f: begin
        info_o.is_alpha = 1'b1;
        info_o.value    = 6'd63;
      end
      default: begin
        info_o.is_alpha = 1'b0;
      end
    endcase
  end

endmodule

>>> sv/b64_step.sv
// per-byte decode step: quartet gathering, pad checks, byte emission, end of stream
// depends on b64_pkg
module b64_step (
  input  b64_pkg::dec_state_t  state_i,
  input  b64_pkg::char_info_t  info_i,
  input  logic                 eos_i,
  input  logic                 skip_junk_i,
  output b64_pkg::dec_state_t  state_o,
  output b64_pkg::dec_result_t result_o
);

  always_comb begin
    logic                        inv;
    logic                        wr;
    logic [b64_pkg::SextetW-1:0] val;
    logic [b64_pkg::SextetW-1:0] q0, q1, q2, q3;

    inv      = 1'b0;
    wr       = 1'b0;
    val      = '0;
    state_o  = state_i;
    result_o = '0;
    result_o.status = b64_pkg::StOk;

    if (state_i.error_seen) begin
      inv = 1'b1;
    end else if (info_i.is_space) begin
      inv = 1'b0;
    end else if (state_i.data_finished) begin
      // only blanks may follow the end of data, or garbage when skip_junk is set
      if (info_i.is_alpha || info_i.is_pad || !skip_junk_i) begin
        inv = 1'b1;
      end
    end else if (info_i.is_pad) begin
      if (state_i.fill_count < 2'd2) begin
        inv = 1'b1;
      end else begin
        wr  = 1'b1;
        val = b64_pkg::PadMark;
      end
    end else if (!info_i.is_alpha) begin
      inv = !skip_junk_i;
    end else if (state_i.fill_count != 2'd0 &&
                 state_i.sextets[state_i.fill_count - 2'd1] == b64_pkg::PadMark) begin
      // data after a pad
      inv = 1'b1;
    end else begin
      wr  = 1'b1;
      val = {1'b0, info_i.value};
    end

    q0 = state_i.sextets[0];
    q1 = state_i.sextets[1];
    q2 = state_i.sextets[2];
    q3 = val;

    if (wr) begin
      state_o.sextets[state_i.fill_count] = val;
      if (state_i.fill_count == 2'd3) begin
        if (q0 == b64_pkg::PadMark || q1 == b64_pkg::PadMark ||
            (q2 == b64_pkg::PadMark && q3 != b64_pkg::PadMark)) begin
          inv = 1'b1;
        end else begin
          result_o.byte0 = {q0[5:0], q1[5:4]};
          if (q2 == b64_pkg::PadMark) begin
            result_o.count         = 2'd1;
            state_o.data_finished  = 1'b1;
          end else begin
            result_o.byte1 = {q1[3:0], q2[5:2]};
            if (q3 == b64_pkg::PadMark) begin
              result_o.count        = 2'd2;
              state_o.data_finished = 1'b1;
            end else begin
              result_o.byte2 = {q2[1:0], q3[5:0]};
              result_o.count = 2'd3;
            end
          end
          state_o.fill_count = 2'd0;
        end
      end else begin
        state_o.fill_count = state_i.fill_count + 2'd1;
      end
    end

    if (inv) begin
      state_o.error_seen = 1'b1;
      result_o.byte0     = '0;
      result_o.byte1     = '0;
      result_o.byte2     = '0;
      result_o.count     = 2'd0;
      result_o.status    = b64_pkg::StInvalid;
    end

    if (eos_i) begin
      if (!inv && state_o.fill_count != 2'd0) begin
        result_o.status = b64_pkg::StShort;
      end
      state_o = '0;
    end
  end

endmodule

>>> sv/base64_strict_stream_decoder.sv
// top level of the strict base64 stream decoder: handshakes, apb register, state
// depends on b64_pkg, b64_char_class and b64_step
//
// usage
//   input channel: one text byte per transfer (in_byte_i, end_of_stream_i)
//   under in_valid_i / in_ready_o
//   output channel: exactly one result per input transfer (up to three decoded
//   bytes, out_count_o, status_o) under out_valid_o / out_ready_i
//   apb port: register 0 at byte address 0, bit 0 = skip_junk; pready is
//   tied high and writes land in the access phase
// timing
//   the byte is captured in an input register; the decode step runs on the
//   held byte and loads the output register once that is free or draining
//   throughput is one byte per cycle while out_ready_i stays high: the decode
//   step is combinational logic between the input register and the output
//   register
// reset
//   clears the quartet, fill count, finished and error flags, skip_junk
//   and both valid flags
// back pressure
//   when out_ready_i is low the result holds; one more byte can sit in the
//   input register, after which in_ready_o drops
// an invalid byte sets a sticky error until end of stream; end_of_stream_i
// reports a partial quartet and then clears the decoder state
module base64_strict_stream_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  in_byte_i,
  input  logic                        end_of_stream_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  out_byte0_o,
  output logic [7:0]                  out_byte1_o,
  output logic [7:0]                  out_byte2_o,
  output logic [1:0]                  out_count_o,
  output logic [1:0]                  status_o,
  // apb configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [b64_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // configuration register
  logic skip_junk_q, skip_junk_d;
  logic cfg_sel;

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       eos_q, eos_d;

  // decoder state and output register
  b64_pkg::dec_state_t  state_q, state_d;
  b64_pkg::dec_state_t  step_state;
  b64_pkg::dec_result_t step_res;
  b64_pkg::dec_result_t res_q, res_d;
  logic                 out_vld_q, out_vld_d;

  b64_pkg::char_info_t  info;
  logic                 advance;

  // apb: register index is the word address
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[b64_pkg::PaddrW-1:2] == b64_pkg::RegSkipJunk);
  assign prdata  = cfg_sel ? {31'd0, skip_junk_q} : 32'd0;

  always_comb begin
    skip_junk_d = skip_junk_q;
    if (psel && penable && pwrite && pready && cfg_sel) begin
      skip_junk_d = pwdata[0];
    end
  end

  // the held byte moves on when the output register is free or being drained
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_comb begin
    in_vld_d  = in_vld_q;
    in_byte_d = in_byte_q;
    eos_d     = eos_q;
    if (in_ready_o) begin
      in_vld_d  = in_valid_i;
      in_byte_d = in_byte_i;
      eos_d     = end_of_stream_i;
    end
  end

  b64_char_class u_class (
    .char_i (in_byte_q),
    .info_o (info)
  );

  b64_step u_step (
    .state_i     (state_q),
    .info_i      (info),
    .eos_i       (eos_q),
    .skip_junk_i (skip_junk_q),
    .state_o     (step_state),
    .result_o    (step_res)
  );

  // state only moves together with a transfer into the output register
  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    out_vld_d = out_vld_q;
    if (advance) begin
      state_d   = step_state;
      res_d     = step_res;
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_junk_q <= 1'b0;
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      state_q     <= '0;
    end else begin
      skip_junk_q <= skip_junk_d;
      in_vld_q    <= in_vld_d;
      out_vld_q   <= out_vld_d;
      state_q     <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    eos_q     <= eos_d;
    res_q     <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_byte0_o = res_q.byte0;
  assign out_byte1_o = res_q.byte1;
  assign out_byte2_o = res_q.byte2;
  assign out_count_o = res_q.count;
  assign status_o    = res_q.status;

  // decoded bytes only come with an ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.count != 2'd0) |-> (res_q.status == b64_pkg::StOk))
    else $error("decoded bytes reported with a non-ok status");

  // a sticky error turns the next result into an invalid one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && state_q.error_seen) |=> (res_q.status == b64_pkg::StInvalid))
    else $error("byte after an error was not reported invalid");

  // a finished stream never holds a partial quartet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.data_finished |-> (state_q.fill_count == 2'd0))
    else $error("partial quartet after end of data");

  // end of stream leaves clean state behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && eos_q) |=> (state_q == '0))
    else $error("state not cleared after end of stream");

endmodule

>>> verif/b64_decode_checker.sv
`timescale 1ns / 1ps
// result checker for the strict base64 stream decoder: follows apb writes and
// input transfers, predicts each result and compares the output transfers
// depends on b64_pkg
module b64_decode_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [7:0]                 in_byte_i,
  input  logic                       end_of_stream_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [7:0]                 out_byte0_i,
  input  logic [7:0]                 out_byte1_i,
  input  logic [7:0]                 out_byte2_i,
  input  logic [1:0]                 out_count_i,
  input  logic [1:0]                 status_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [b64_pkg::PaddrW-1:0] paddr_i,
  input  logic [31:0]                pwdata_i,
  output int                         pending_o,
  output int                         fail_count_o
);

  localparam logic [b64_pkg::PaddrW-1:0] AddrSkipJunk = {b64_pkg::RegSkipJunk, 2'b00};

  logic [b64_pkg::SextetW-1:0] quartet [b64_pkg::QuartetLen];
  logic [1:0]                  fill;
  logic                        finished;
  logic                        err_seen;
  logic                        skip_garbage;
  b64_pkg::dec_result_t        expected_q [$];
  int                          mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d || c == 8'h0c || c == 8'h0b;
  endfunction

  // 0..63 for an alphabet character, 8'hff otherwise
  function automatic logic [7:0] sextet_value(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) return c - 8'h41;
    if (c >= 8'h61 && c <= 8'h7a) return c - 8'h61 + 8'd26;
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30 + 8'd52;
    if (c == 8'h2b) return 8'd62;
    if (c == 8'h2f) return 8'd63;
    return 8'hff;
  endfunction

  function automatic void clear_stream_state();
    foreach (quartet[i]) quartet[i] = '0;
    fill     = '0;
    finished = 1'b0;
    err_seen = 1'b0;
  endfunction

  function automatic b64_pkg::dec_result_t decode_text_byte(input logic [7:0] c,
                                                            input logic eos);
    b64_pkg::dec_result_t        res;
    logic [7:0]                  v;
    logic                        stored;
    logic [b64_pkg::SextetW-1:0] q0, q1, q2, q3;
    res        = '0;
    res.status = b64_pkg::StOk;
    stored     = 1'b0;
    v          = sextet_value(c);
    if (err_seen) begin
      res.status = b64_pkg::StInvalid;
    end else if (!is_blank(c)) begin
      if (finished) begin
        // only blanks may follow the end of the data, or garbage when skip_garbage is set
        if (v != 8'hff || c == b64_pkg::CharPad || !skip_garbage) begin
          res.status = b64_pkg::StInvalid;
        end
      end else if (c == b64_pkg::CharPad) begin
        if (fill < 2'd2) begin
          res.status = b64_pkg::StInvalid;
        end else begin
          quartet[fill] = b64_pkg::PadMark;
          stored = 1'b1;
        end
      end else if (v == 8'hff) begin
        if (!skip_garbage) res.status = b64_pkg::StInvalid;
      end else if (fill != 2'd0 && quartet[fill - 2'd1] == b64_pkg::PadMark) begin
        res.status = b64_pkg::StInvalid;
      end else begin
        quartet[fill] = v[b64_pkg::SextetW-1:0];
        stored = 1'b1;
      end
    end
    if (stored) begin
      if (fill == 2'd3) begin
        q0 = quartet[0];
        q1 = quartet[1];
        q2 = quartet[2];
        q3 = quartet[3];
        if (q0 == b64_pkg::PadMark || q1 == b64_pkg::PadMark ||
            (q2 == b64_pkg::PadMark && q3 != b64_pkg::PadMark)) begin
          res.status = b64_pkg::StInvalid;
        end else begin
          res.count = 2'd1;
          res.byte0 = {q0[5:0], q1[5:4]};
          if (q2 == b64_pkg::PadMark) begin
            finished = 1'b1;
          end else begin
            res.count = 2'd2;
            res.byte1 = {q1[3:0], q2[5:2]};
            if (q3 == b64_pkg::PadMark) begin
              finished = 1'b1;
            end else begin
              res.count = 2'd3;
              res.byte2 = {q2[1:0], q3[5:0]};
            end
          end
          fill = 2'd0;
        end
      end else begin
        fill = fill + 2'd1;
      end
    end
    if (res.status == b64_pkg::StInvalid) begin
      err_seen  = 1'b1;
      res.count = 2'd0;
      res.byte0 = '0;
      res.byte1 = '0;
      res.byte2 = '0;
    end
    if (eos) begin
      if (res.status == b64_pkg::StOk && fill != 2'd0) res.status = b64_pkg::StShort;
      clear_stream_state();
    end
    return res;
  endfunction

  function automatic void compare_result(input b64_pkg::dec_result_t exp);
    if (out_byte0_i !== exp.byte0) begin
      $error("out_byte0: expected %0h, got %0h", exp.byte0, out_byte0_i);
      mismatches++;
    end
    if (out_byte1_i !== exp.byte1) begin
      $error("out_byte1: expected %0h, got %0h", exp.byte1, out_byte1_i);
      mismatches++;
    end
    if (out_byte2_i !== exp.byte2) begin
      $error("out_byte2: expected %0h, got %0h", exp.byte2, out_byte2_i);
      mismatches++;
    end
    if (out_count_i !== exp.count) begin
      $error("out_count: expected %0d, got %0d", exp.count, out_count_i);
      mismatches++;
    end
    if (status_i !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, status_i);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_stream_state();
      skip_garbage = 1'b0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == AddrSkipJunk) begin
        skip_garbage = pwdata_i[0];
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(decode_text_byte(in_byte_i, end_of_stream_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no input waiting: count %0d status %0d",
                 out_count_i, status_i);
          mismatches++;
        end else begin
          compare_result(expected_q.pop_front());
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// top of the strict base64 decoder testbench: clock, reset, apb writes and
// text streams under several idle patterns; depends on b64_pkg, the decoder
// and b64_decode_checker, which predicts and compares every result
module testbench;

  localparam logic [b64_pkg::PaddrW-1:0] AddrSkipJunk = {b64_pkg::RegSkipJunk, 2'b00};

  // directed text, {end_of_stream, byte}
  localparam logic [8:0] DirectedText [25] = '{
    // alphabet extremes in one full quartet
    {1'b0, 8'h41}, {1'b0, 8'h2f}, {1'b0, 8'h2b}, {1'b0, 8'h39},
    // pad in the last position ends the data with two bytes
    {1'b0, 8'h7a}, {1'b0, 8'h5a}, {1'b0, 8'h30}, {1'b0, 8'h3d},
    // tab is skipped, then data after the finish, then a sticky error
    {1'b0, 8'h09}, {1'b0, 8'h51}, {1'b0, 8'hff}, {1'b1, 8'h20},
    // double pad, then a pad after the finish closing the stream
    {1'b0, 8'h61}, {1'b0, 8'h62}, {1'b0, 8'h3d}, {1'b0, 8'h3d}, {1'b1, 8'h3d},
    // pad too early, on a byte that also ends the stream
    {1'b1, 8'h3d},
    // data after a pad inside the quartet, stream closed on a zero byte
    {1'b0, 8'h51}, {1'b0, 8'h55}, {1'b0, 8'h3d}, {1'b0, 8'h41}, {1'b1, 8'h00},
    // stream ending mid-quartet
    {1'b0, 8'h51}, {1'b1, 8'h51}
  };

  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       in_valid_i      = 1'b0;
  logic                       in_ready_o;
  logic [7:0]                 in_byte_i       = '0;
  logic                       end_of_stream_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i     = 1'b0;
  logic [7:0]                 out_byte0_o;
  logic [7:0]                 out_byte1_o;
  logic [7:0]                 out_byte2_o;
  logic [1:0]                 out_count_o;
  logic [1:0]                 status_o;
  logic                       psel            = 1'b0;
  logic                       penable         = 1'b0;
  logic                       pwrite          = 1'b0;
  logic [b64_pkg::PaddrW-1:0] paddr           = '0;
  logic [31:0]                pwdata          = '0;
  logic [31:0]                prdata;
  logic                       pready;

  int                pending;
  int                fail_count;
  int                sender_idle_pct    = 0;
  int                receiver_stall_pct = 0;
  int                items_sent         = 0;
  logic [7:0]        text_q [$];

  always #4 clk_i = ~clk_i;

  base64_strict_stream_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte0_o     (out_byte0_o),
    .out_byte1_o     (out_byte1_o),
    .out_byte2_o     (out_byte2_o),
    .out_count_o     (out_count_o),
    .status_o        (status_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  b64_decode_checker decode_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte0_i     (out_byte0_o),
    .out_byte1_i     (out_byte1_o),
    .out_byte2_i     (out_byte2_o),
    .out_count_i     (out_count_o),
    .status_i        (status_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  // receiver back pressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [7:0] alphabet_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + {2'b00, v};
    if (v < 6'd52) return 8'h61 + {2'b00, v} - 8'd26;
    if (v < 6'd62) return 8'h30 + {2'b00, v} - 8'd52;
    if (v == 6'd62) return 8'h2b;
    return 8'h2f;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(5))
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return 8'h0a;
      3:       return 8'h0d;
      4:       return 8'h0c;
      default: return 8'h0b;
    endcase
  endfunction

  // each text character may get a blank or a stray byte in front of it
  function automatic void push_text_char(input logic [7:0] c);
    if ($urandom_range(99) < 10) text_q.push_back(blank_char());
    if ($urandom_range(99) < 2) text_q.push_back(8'($urandom_range(255)));
    text_q.push_back(c);
  endfunction

  // encodes 0..9 random bytes into padded text
  function automatic void build_encoded_text();
    logic [7:0] raw [9];
    logic [7:0] b0, b1, b2;
    int         n;
    n = $urandom_range(9);
    foreach (raw[i]) raw[i] = 8'($urandom_range(255));
    for (int g = 0; g < n; g += 3) begin
      b0 = raw[g];
      b1 = (g + 1 < n) ? raw[g + 1] : 8'h00;
      b2 = (g + 2 < n) ? raw[g + 2] : 8'h00;
      push_text_char(alphabet_char(b0[7:2]));
      push_text_char(alphabet_char({b0[1:0], b1[7:4]}));
      push_text_char((g + 1 < n) ? alphabet_char({b1[3:0], b2[7:6]}) : b64_pkg::CharPad);
      push_text_char((g + 2 < n) ? alphabet_char(b2[5:0]) : b64_pkg::CharPad);
    end
  endfunction

  // called at a rising edge; returns at the edge where the byte transfers.
  // valid stays high into the next byte unless an idle gap is drawn
  task automatic send_text_byte(input logic [7:0] c, input logic eos);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i      <= 1'b1;
    in_byte_i       <= c;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic apb_write(input logic [b64_pkg::PaddrW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drop valid and wait for every outstanding result, then let the two-stage
  // pipe settle before anything touches the register
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // one stream: mostly well-formed text, some of it broken, some pure noise
  task automatic send_stream();
    int   kind;
    int   pos;
    logic eos_last;
    text_q.delete();
    eos_last = 1'b1;
    kind = $urandom_range(99);
    if (kind < 15) begin
      // random bytes over the whole range, stream not always closed
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(255)));
      eos_last = ($urandom_range(3) != 0);
    end else begin
      build_encoded_text();
      if (kind < 32 && text_q.size() > 0) begin
        pos = $urandom_range(text_q.size() - 1);
        case ($urandom_range(3))
          0: text_q[pos] = b64_pkg::CharPad;
          1: text_q[pos] = 8'($urandom_range(255));
          // truncation leaves a partial quartet
          2: repeat ($urandom_range(1, 3)) if (text_q.size() > 0) void'(text_q.pop_back());
          // more data behind the text, illegal after a pad
          default: begin
            repeat ($urandom_range(1, 2)) text_q.push_back(alphabet_char(6'($urandom_range(63))));
          end
        endcase
      end
    end
    if (text_q.size() == 0) text_q.push_back(blank_char());
    foreach (text_q[i]) begin
      send_text_byte(text_q[i], (i == text_q.size() - 1) ? eos_last : 1'b0);
    end
  endtask

  task automatic run_phase(input int idle_mode, input logic skip_garbage, input int item_goal);
    int first_item;
    case (idle_mode)
      0: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      1: begin
        sender_idle_pct    = 50;
        receiver_stall_pct = 0;
      end
      2: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 50;
      end
      default: begin
        sender_idle_pct    = 6;
        receiver_stall_pct = 6;
      end
    endcase
    // register only changes while the decoder is idle
    apb_write(AddrSkipJunk, {31'd0, skip_garbage});
    first_item = items_sent;
    while (items_sent - first_item < item_goal) send_stream();
    drain_pipeline();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed part with garbage reported as invalid
    apb_write(AddrSkipJunk, 32'd0);
    foreach (DirectedText[i]) send_text_byte(DirectedText[i][7:0], DirectedText[i][8]);
    drain_pipeline();
    // random part: every idle pattern under both garbage settings
    for (int phase = 0; phase < 8; phase++) begin
      run_phase(phase % 4, phase >= 4, 215);
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
